/* hdl/tiu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer / interrupt unit package
// Shared codes, widths, word types and a helper function.
// ----------------------------------------------------------------------------
package tiu_pkg;

    // divider prescaler rate
    localparam int DIVIDER_RATE = 256;
    localparam int MAX_CYCLES   = 63;
    localparam int DIV_PS_W     = $clog2(DIVIDER_RATE);
    localparam int DIV_SUM_W    = $clog2(DIVIDER_RATE + MAX_CYCLES + 1);
    localparam int DIV_SUB_N    = ((MAX_CYCLES - 1) / DIVIDER_RATE) + 1;

    localparam int CNT_PS_W  = 10;
    localparam int CNT_SUM_W = CNT_PS_W + 1;

    // operation codes
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_WRITE   = 3'd1;
    localparam logic [2:0] FUNC_READ    = 3'd2;
    localparam logic [2:0] FUNC_SERVICE = 3'd3;
    localparam logic [2:0] FUNC_REQUEST = 3'd4;

    // register indexes
    localparam logic [2:0] REG_DIVIDER = 3'd0;
    localparam logic [2:0] REG_COUNTER = 3'd1;
    localparam logic [2:0] REG_MODULO  = 3'd2;
    localparam logic [2:0] REG_CONTROL = 3'd3;
    localparam logic [2:0] REG_REQUEST = 3'd4;
    localparam logic [2:0] REG_ENABLE  = 3'd5;

    // configuration register indexes
    localparam logic CFG_BOOT_ROM = 1'b0;

    localparam logic [7:0] TIMER_IRQ_MASK = 8'h04;
    localparam logic [7:0] VECTOR_BASE    = 8'h40;
    localparam int         NUM_IRQ        = 5;
    localparam logic [2:0] DISPATCH_CYC   = 3'd5;
    localparam logic [15:0] SP_STEP       = 16'd2;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  cycles;
        logic [2:0]  reg_index;
        logic [7:0]  wdata;
        logic [15:0] pc;
        logic [15:0] sp;
    } t_item;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        taken;
        logic [7:0]  vector;
        logic [15:0] new_sp;
        logic [15:0] push_pc;
        logic [2:0]  extra_cycles;
    } t_result;

    // counter prescaler rate selected by control[1:0]
    function automatic logic [CNT_SUM_W-1:0] counter_rate(input logic [1:0] sel);
        logic [CNT_SUM_W-1:0] rate;
        unique case (sel)
            2'd0: rate = CNT_SUM_W'(1024);
            2'd1: rate = CNT_SUM_W'(16);
            2'd2: rate = CNT_SUM_W'(64);
            default: rate = CNT_SUM_W'(256);
        endcase
        return rate;
    endfunction

endpackage

/* hdl/tiu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer / interrupt unit core
// Architectural state and the combinational update and result logic.
// ----------------------------------------------------------------------------
module tiu_core
    import tiu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_boot_rom,
    input  t_item   i_item,
    output t_result o_result
);

    logic [7:0]          r_divider, n_divider;
    logic [7:0]          r_counter, n_counter;
    logic [7:0]          r_modulo, n_modulo;
    logic [7:0]          r_control, n_control;
    logic [7:0]          r_request, n_request;
    logic [7:0]          r_enable, n_enable;
    logic                r_master_enable, n_master_enable;
    logic [DIV_PS_W-1:0] r_div_ps, n_div_ps;
    logic [CNT_PS_W-1:0] r_cnt_ps, n_cnt_ps;

    // tick datapath
    logic [DIV_SUM_W-1:0] w_div_sum, w_div_rem;
    logic                 w_div_hit;
    logic [CNT_SUM_W-1:0] w_cnt_rate, w_cnt_sum, w_cnt_rem;
    logic                 w_cnt_hit;
    logic [NUM_IRQ-1:0]   w_pending;
    logic [2:0]           w_irq_idx;
    logic                 w_irq_any;
    t_result              w_res;

    always_comb begin
        w_div_sum = DIV_SUM_W'(r_div_ps) + DIV_SUM_W'(i_item.cycles);
        w_div_hit = (w_div_sum >= DIV_SUM_W'(DIVIDER_RATE));
        w_div_rem = w_div_sum;
        for (int k = 0; k < DIV_SUB_N; k++) begin
            if (w_div_rem >= DIV_SUM_W'(DIVIDER_RATE)) begin
                w_div_rem = w_div_rem - DIV_SUM_W'(DIVIDER_RATE);
            end
        end
        w_cnt_rate = counter_rate(r_control[1:0]);
        w_cnt_sum  = CNT_SUM_W'(r_cnt_ps) + CNT_SUM_W'(i_item.cycles);
        w_cnt_hit  = (w_cnt_sum >= w_cnt_rate);
        // rates are powers of two
        w_cnt_rem  = w_cnt_sum & (w_cnt_rate - CNT_SUM_W'(1));
    end

    always_comb begin
        w_pending = r_request[NUM_IRQ-1:0] & r_enable[NUM_IRQ-1:0];
        w_irq_any = |w_pending;
        w_irq_idx = '0;
        for (int i = NUM_IRQ - 1; i >= 0; i--) begin
            if (w_pending[i]) begin
                w_irq_idx = 3'(i);
            end
        end
    end

    always_comb begin
        n_divider       = r_divider;
        n_counter       = r_counter;
        n_modulo        = r_modulo;
        n_control       = r_control;
        n_request       = r_request;
        n_enable        = r_enable;
        n_master_enable = r_master_enable;
        n_div_ps        = r_div_ps;
        n_cnt_ps        = r_cnt_ps;
        w_res           = '0;

        unique case (i_item.func)
            FUNC_TICK: begin
                n_div_ps = w_div_rem[DIV_PS_W-1:0];
                if (w_div_hit) begin
                    n_divider = r_divider + 8'd1;
                end
                if (r_control[2]) begin
                    n_cnt_ps = w_cnt_hit ? w_cnt_rem[CNT_PS_W-1:0]
                                         : w_cnt_sum[CNT_PS_W-1:0];
                    if (w_cnt_hit) begin
                        if (r_counter == 8'hFF) begin
                            n_counter = r_modulo;
                            if (!i_boot_rom) begin
                                n_master_enable = 1'b1;
                                n_request       = r_request | TIMER_IRQ_MASK;
                                n_enable        = r_enable | TIMER_IRQ_MASK;
                            end
                        end else begin
                            n_counter = r_counter + 8'd1;
                        end
                    end
                end
            end
            FUNC_WRITE: begin
                unique case (i_item.reg_index)
                    REG_DIVIDER: n_divider = '0;
                    REG_COUNTER: n_counter = i_item.wdata;
                    REG_MODULO:  n_modulo  = i_item.wdata;
                    REG_CONTROL: n_control = i_item.wdata;
                    REG_REQUEST: n_request = i_item.wdata;
                    REG_ENABLE:  n_enable  = i_item.wdata;
                    default: ;
                endcase
            end
            FUNC_READ: begin
                unique case (i_item.reg_index)
                    REG_DIVIDER: w_res.rdata = r_divider;
                    REG_COUNTER: w_res.rdata = r_counter;
                    REG_MODULO:  w_res.rdata = r_modulo;
                    REG_CONTROL: w_res.rdata = r_control;
                    REG_REQUEST: w_res.rdata = r_request;
                    REG_ENABLE:  w_res.rdata = r_enable;
                    default:     w_res.rdata = '0;
                endcase
            end
            FUNC_SERVICE: begin
                if (r_master_enable && !i_boot_rom && w_irq_any) begin
                    n_master_enable          = 1'b0;
                    n_request[w_irq_idx]     = 1'b0;
                    w_res.taken              = 1'b1;
                    w_res.vector             = VECTOR_BASE + {2'b00, w_irq_idx, 3'b000};
                    w_res.new_sp             = i_item.sp - SP_STEP;
                    w_res.push_pc            = i_item.pc;
                    w_res.extra_cycles       = DISPATCH_CYC;
                end
            end
            FUNC_REQUEST: begin
                if (!i_boot_rom) begin
                    n_master_enable = 1'b1;
                    n_request       = r_request | i_item.wdata;
                    n_enable        = r_enable | i_item.wdata;
                end
            end
            default: ;
        endcase
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider       <= '0;
            r_counter       <= '0;
            r_modulo        <= '0;
            r_control       <= '0;
            r_request       <= '0;
            r_enable        <= '0;
            r_master_enable <= 1'b0;
            r_div_ps        <= '0;
            r_cnt_ps        <= '0;
        end else if (i_accept) begin
            r_divider       <= n_divider;
            r_counter       <= n_counter;
            r_modulo        <= n_modulo;
            r_control       <= n_control;
            r_request       <= n_request;
            r_enable        <= n_enable;
            r_master_enable <= n_master_enable;
            r_div_ps        <= n_div_ps;
            r_cnt_ps        <= n_cnt_ps;
        end
    end

`ifndef SYNTH
    a_taken_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_res.taken) |-> (r_master_enable && !i_boot_rom))
        else $error("interrupt dispatched while blocked");

    a_taken_clears_ime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_res.taken) |=> !r_master_enable)
        else $error("master enable not cleared on dispatch");

    a_boot_holds_ime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_boot_rom && (i_item.func != FUNC_SERVICE)) |=>
        (r_master_enable == $past(r_master_enable)))
        else $error("master enable changed during boot");

    a_div_ps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIV_SUM_W'(r_div_ps) < DIV_SUM_W'(DIVIDER_RATE))
        else $error("divider prescaler out of range");
`endif

endmodule

/* hdl/timer_interrupt_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer / interrupt unit top level
// Stream ports, APB configuration and registered result word.
// ----------------------------------------------------------------------------
// Each input word (tick, register write, register read, service or request,
// chosen by s_axis_tuser) is executed in the cycle it is accepted and yields
// exactly one result word from the output register in the next cycle. A new word
// is accepted every cycle while the output register is empty or being drained,
// so throughput is one word per clock. The APB register at addresses with
// paddr[2] clear (bit 0) is the boot-ROM flag, set at reset, which blocks
// interrupt requests and dispatch while high; write it only while idle.
module timer_interrupt_unit_top
    import tiu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // s_axis_tdata: cycles[5:0], reg_index[8:6], wdata[16:9], pc[32:17],
    // sp[48:33], zero[55:49]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: func[2:0]
    input  logic [2:0]            s_axis_tuser,
    // m_axis_tdata: rdata[7:0], taken[8], vector[16:9], new_sp[32:17],
    // push_pc[48:33], extra_cycles[51:49], zero[55:52]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic    r_boot_rom;
    logic    r_m_valid;
    t_result r_m_res;
    t_item   w_item;
    t_result w_res;
    logic    w_accept;
    logic    w_cfg_wr;

    assign s_axis_tready = i_rst_n && (!r_m_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_item.func      = s_axis_tuser;
    assign w_item.cycles    = s_axis_tdata[5:0];
    assign w_item.reg_index = s_axis_tdata[8:6];
    assign w_item.wdata     = s_axis_tdata[16:9];
    assign w_item.pc        = s_axis_tdata[32:17];
    assign w_item.sp        = s_axis_tdata[48:33];

    tiu_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_boot_rom (r_boot_rom),
        .i_item     (w_item),
        .o_result   (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_m_res.extra_cycles, r_m_res.push_pc,
                            r_m_res.new_sp, r_m_res.vector, r_m_res.taken,
                            r_m_res.rdata};

    // APB config
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_rom <= 1'b1;
        end else if (w_cfg_wr && (paddr[2] == CFG_BOOT_ROM)) begin
            r_boot_rom <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == CFG_BOOT_ROM) ? {31'd0, r_boot_rom} : 32'd0;

endmodule
